// ===== src/acia_pkg.sv =====
// Shared types, codes and format tables for the asynchronous serial interface.
`timescale 1ns / 1ps
`default_nettype none

package acia_pkg;

    localparam logic [3:0] OP_CTRL_WR = 4'd0;
    localparam logic [3:0] OP_DATA_WR = 4'd1;
    localparam logic [3:0] OP_STAT_RD = 4'd2;
    localparam logic [3:0] OP_DATA_RD = 4'd3;
    localparam logic [3:0] OP_RXC     = 4'd4;
    localparam logic [3:0] OP_TXC     = 4'd5;
    localparam logic [3:0] OP_RXD     = 4'd6;
    localparam logic [3:0] OP_CTS     = 4'd7;
    localparam logic [3:0] OP_DCD     = 4'd8;

    localparam logic [7:0] ST_RDRF = 8'h01;
    localparam logic [7:0] ST_TDRE = 8'h02;
    localparam logic [7:0] ST_DCD  = 8'h04;
    localparam logic [7:0] ST_CTS  = 8'h08;
    localparam logic [7:0] ST_FE   = 8'h10;
    localparam logic [7:0] ST_OVRN = 8'h20;
    localparam logic [7:0] ST_PE   = 8'h40;
    localparam logic [7:0] ST_IRQ  = 8'h80;

    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_ODD  = 2'd1;
    localparam logic [1:0] PAR_EVEN = 2'd2;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_STOP  = 2'd2;

    localparam logic [1:0] CIRQ_NONE   = 2'd0;
    localparam logic [1:0] CIRQ_STATUS = 2'd1;
    localparam logic [1:0] CIRQ_DATA   = 2'd2;

    localparam logic [1:0] TC_RTS_HIGH = 2'd2;
    localparam logic [1:0] TC_BREAK    = 2'd3;
    localparam logic [1:0] TC_TX_IRQ   = 2'd1;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] data;
        logic       level;
    } item_in_t;

    typedef struct packed {
        logic       irq_n;
        logic       rts;
        logic       txd;
        logic [7:0] rd;
    } item_out_t;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] tx_data;
        logic [7:0] rx_data;
        logic       first_reset;
        logic [1:0] cirq;
        logic       ovr;
        logic [6:0] divide;
        logic [3:0] frame;
        logic [1:0] parity;
        logic [1:0] stops;
        logic       brk;
        logic       tx_irq_on;
        logic       rx_irq_on;
        logic       rts;
        logic       txd;
        logic       irq_n;
        logic       txc;
        logic       rxc;
        logic       rx_level;
        logic       carrier;
        logic [1:0] tx_phase;
        logic [3:0] tx_bit;
        logic [7:0] tx_shift;
        logic       tx_par;
        logic [6:0] tx_tick;
        logic [1:0] rx_phase;
        logic [3:0] rx_bit;
        logic [9:0] rx_shift;
        logic       rx_par;
        logic [6:0] rx_tick;
    } acia_state_t;

    localparam acia_state_t STATE_RESET = '{
        status:      ST_TDRE,
        first_reset: 1'b1,
        rts:         1'b1,
        txd:         1'b1,
        irq_n:       1'b1,
        rx_level:    1'b1,
        default:     '0
    };

    function automatic logic [6:0] divide_of(input logic [1:0] sel);
        logic [6:0] d;
        case (sel)
            2'd0:    d = 7'd1;
            2'd1:    d = 7'd16;
            2'd2:    d = 7'd64;
            default: d = 7'd0;
        endcase
        return d;
    endfunction

    function automatic logic [3:0] frame_of(input logic [2:0] ws);
        return (ws == 3'd6 || ws == 3'd7) ? 4'd9 : 4'd8;
    endfunction

    function automatic logic [1:0] parity_of(input logic [2:0] ws);
        logic [1:0] p;
        case (ws)
            3'd4, 3'd5:             p = PAR_NONE;
            3'd1, 3'd3, 3'd7:       p = PAR_ODD;
            default:                p = PAR_EVEN;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] stops_of(input logic [2:0] ws);
        return (ws == 3'd0 || ws == 3'd1 || ws == 3'd4) ? 2'd2 : 2'd1;
    endfunction

    function automatic acia_state_t irq_update(input acia_state_t s);
        acia_state_t r;
        logic        tx_req;
        logic        rx_req;
        logic        lvl;
        r = s;
        tx_req = s.tx_irq_on && ((s.status & ST_TDRE) != 8'h00)
                 && ((s.status & ST_CTS) == 8'h00);
        rx_req = s.rx_irq_on && (((s.status & ST_RDRF) != 8'h00) || (s.cirq != CIRQ_NONE));
        lvl = !(tx_req || rx_req);
        if (lvl != s.irq_n)
        begin
            r.irq_n = lvl;
            r.status = lvl ? (s.status & ~ST_IRQ) : (s.status | ST_IRQ);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/acia_serial_interface.sv =====
// Top level of the asynchronous serial interface: item register, event core, result register.
`timescale 1ns / 1ps
`default_nettype none

// Each input item is one event (register write, register read or a new level on a
// serial line) and yields exactly one result item carrying the read byte and the
// TXD, RTS and active-low IRQ line levels after the event. Items pass through an
// input register, combinational event logic and a result register; one item is
// taken every cycle while the result is not stalled by m_tready, and the result register lets a new
// item enter while the previous result waits for m_tready.

module acia_serial_interface (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [acia_pkg::IN_TDATA_W-1:0]    s_tdata,  // bus_data, line_level
    input  wire logic [acia_pkg::IN_TUSER_W-1:0]    s_tuser,  // operation
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [acia_pkg::OUT_TDATA_W-1:0]        m_tdata   // read_data, txd_line,
                                                              // rts_line, irq_line_n
);

    logic                in_valid_reg;
    acia_pkg::item_in_t  in_item_reg;
    logic                out_valid_reg;
    acia_pkg::item_out_t out_item_reg;
    acia_pkg::item_out_t result;
    logic                fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.op    <= s_tuser[3:0];
            in_item_reg.data  <= s_tdata[7:0];
            in_item_reg.level <= s_tdata[8];
        end
        if (fire)
        begin
            out_item_reg <= result;
        end
    end

    acia_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (fire),
        .item   (in_item_reg),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_item_reg.irq_n, out_item_reg.rts,
                       out_item_reg.txd, out_item_reg.rd};

endmodule

`default_nettype wire

// ===== src/acia_core.sv =====
// Interface state registers and the per-item event update.
`timescale 1ns / 1ps
`default_nettype none

module acia_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire acia_pkg::item_in_t item,
    output acia_pkg::item_out_t     result
);

    acia_pkg::acia_state_t state_reg;
    acia_pkg::acia_state_t state_next;

    logic [7:0] rd;
    logic [2:0] ws;
    logic [1:0] tc;
    logic       rts_v;
    logic [6:0] tick_inc;
    logic [3:0] bit_inc;
    logic [9:0] shift_or;
    logic       par_v;
    logic       odd_v;

    always_comb
    begin
        state_next = state_reg;
        rd = '0;
        ws = item.data[4:2];
        tc = item.data[6:5];
        rts_v = 1'b0;
        tick_inc = '0;
        bit_inc = '0;
        shift_or = '0;
        par_v = 1'b0;
        odd_v = (state_reg.parity == acia_pkg::PAR_ODD);
        unique case (item.op)
            acia_pkg::OP_CTRL_WR:
            begin
                state_next.divide = acia_pkg::divide_of(item.data[1:0]);
                state_next.frame = acia_pkg::frame_of(ws);
                state_next.parity = acia_pkg::parity_of(ws);
                state_next.stops = acia_pkg::stops_of(ws);
                state_next.brk = (tc == acia_pkg::TC_BREAK);
                state_next.tx_irq_on = (tc == acia_pkg::TC_TX_IRQ);
                state_next.rx_irq_on = item.data[7];
                rts_v = (tc == acia_pkg::TC_RTS_HIGH);
                if (state_next.divide == '0)
                begin
                    if (state_reg.first_reset)
                    begin
                        rts_v = 1'b1;
                        state_next.first_reset = 1'b0;
                    end
                    state_next.cirq = acia_pkg::CIRQ_NONE;
                    state_next.ovr = 1'b0;
                    state_next.rx_phase = acia_pkg::PH_START;
                    state_next.rx_tick = '0;
                    state_next.tx_phase = acia_pkg::PH_START;
                    state_next.txd = 1'b1;
                    state_next.status = (state_reg.status & acia_pkg::ST_CTS)
                                        | acia_pkg::ST_TDRE
                                        | (state_reg.carrier ? acia_pkg::ST_DCD : 8'h00);
                end
                state_next.rts = rts_v;
                state_next = acia_pkg::irq_update(state_next);
            end
            acia_pkg::OP_DATA_WR:
            begin
                state_next.tx_data = item.data;
                state_next.status = state_reg.status & ~acia_pkg::ST_TDRE;
                state_next = acia_pkg::irq_update(state_next);
            end
            acia_pkg::OP_STAT_RD:
            begin
                rd = state_reg.status;
                if ((rd & acia_pkg::ST_CTS) != 8'h00)
                begin
                    rd = rd & ~acia_pkg::ST_TDRE;
                end
                if (state_reg.cirq == acia_pkg::CIRQ_STATUS)
                begin
                    state_next.cirq = acia_pkg::CIRQ_DATA;
                end
            end
            acia_pkg::OP_DATA_RD:
            begin
                if (state_reg.ovr)
                begin
                    state_next.status = state_reg.status | acia_pkg::ST_OVRN;
                    state_next.ovr = 1'b0;
                end
                else
                begin
                    state_next.status = state_reg.status
                                        & ~(acia_pkg::ST_OVRN | acia_pkg::ST_RDRF);
                end
                if (state_reg.cirq == acia_pkg::CIRQ_DATA)
                begin
                    state_next.cirq = acia_pkg::CIRQ_NONE;
                end
                state_next = acia_pkg::irq_update(state_next);
                rd = state_reg.rx_data;
            end
            acia_pkg::OP_RXC:
            begin
                if (item.level != state_reg.rxc)
                begin
                    state_next.rxc = item.level;
                    if (item.level && state_reg.divide != '0)
                    begin
                        if (state_reg.carrier)
                        begin
                            if ((state_reg.status & acia_pkg::ST_DCD) == 8'h00)
                            begin
                                state_next.status = state_reg.status | acia_pkg::ST_DCD;
                                state_next.cirq = acia_pkg::CIRQ_STATUS;
                            end
                            state_next.rx_phase = acia_pkg::PH_START;
                            state_next.rx_tick = '0;
                        end
                        else
                        begin
                            if (state_reg.cirq == acia_pkg::CIRQ_NONE)
                            begin
                                state_next.status = state_reg.status & ~acia_pkg::ST_DCD;
                            end
                            tick_inc = state_reg.rx_tick + 7'd1;
                            state_next.rx_tick = tick_inc;
                            if (state_reg.rx_phase == acia_pkg::PH_DATA)
                            begin
                                if (tick_inc == state_reg.divide)
                                begin
                                    state_next.rx_tick = '0;
                                    bit_inc = state_reg.rx_bit + 4'd1;
                                    state_next.rx_bit = bit_inc;
                                    shift_or = state_reg.rx_shift
                                        | ((state_reg.rx_level && state_reg.frame < 4'd10)
                                           ? (10'd1 << state_reg.frame) : 10'd0);
                                    state_next.rx_shift = {1'b0, shift_or[9:1]};
                                    par_v = state_reg.rx_par ^ state_reg.rx_level;
                                    state_next.rx_par = par_v;
                                    if (bit_inc == state_reg.frame)
                                    begin
                                        if ((state_next.status & acia_pkg::ST_RDRF) != 8'h00)
                                        begin
                                            state_next.ovr = 1'b1;
                                        end
                                        else
                                        begin
                                            par_v = par_v ^ odd_v;
                                            state_next.rx_par = par_v;
                                            if (state_reg.parity != acia_pkg::PAR_NONE && par_v)
                                            begin
                                                state_next.status = state_next.status
                                                                    | acia_pkg::ST_PE;
                                            end
                                            else
                                            begin
                                                state_next.status = state_next.status
                                                                    & ~acia_pkg::ST_PE;
                                            end
                                            state_next.rx_data = shift_or[8:1];
                                            if (state_reg.frame == 4'd8
                                                && state_reg.parity != acia_pkg::PAR_NONE)
                                            begin
                                                state_next.rx_data[7] = 1'b0;
                                            end
                                            state_next.status = state_next.status
                                                                | acia_pkg::ST_RDRF;
                                        end
                                        state_next.rx_phase = acia_pkg::PH_STOP;
                                    end
                                end
                            end
                            else if (state_reg.rx_phase == acia_pkg::PH_STOP)
                            begin
                                if (tick_inc == state_reg.divide)
                                begin
                                    state_next.rx_tick = '0;
                                    if (!state_reg.rx_level)
                                    begin
                                        state_next.status = state_next.status | acia_pkg::ST_FE;
                                    end
                                    else
                                    begin
                                        state_next.status = state_next.status
                                                            & ~acia_pkg::ST_FE;
                                    end
                                    state_next.rx_phase = acia_pkg::PH_START;
                                end
                            end
                            else
                            begin
                                state_next.rx_phase = acia_pkg::PH_START;
                                if (!state_reg.rx_level)
                                begin
                                    if (tick_inc >= {1'b0, state_reg.divide[6:1]})
                                    begin
                                        state_next.rx_phase = acia_pkg::PH_DATA;
                                        state_next.rx_tick = '0;
                                        state_next.rx_shift = '0;
                                        state_next.rx_par = 1'b0;
                                        state_next.rx_bit = '0;
                                    end
                                end
                                else
                                begin
                                    state_next.rx_tick = '0;
                                end
                            end
                        end
                        state_next = acia_pkg::irq_update(state_next);
                    end
                end
            end
            acia_pkg::OP_TXC:
            begin
                if (item.level != state_reg.txc)
                begin
                    state_next.txc = item.level;
                    if (!item.level && state_reg.divide != '0)
                    begin
                        tick_inc = state_reg.tx_tick + 7'd1;
                        state_next.tx_tick = tick_inc;
                        if (state_reg.tx_phase == acia_pkg::PH_DATA)
                        begin
                            if (tick_inc == state_reg.divide)
                            begin
                                state_next.tx_tick = '0;
                                bit_inc = state_reg.tx_bit + 4'd1;
                                state_next.tx_bit = bit_inc;
                                if (bit_inc != state_reg.frame
                                    || state_reg.parity == acia_pkg::PAR_NONE)
                                begin
                                    state_next.txd = state_reg.tx_shift[0];
                                    state_next.tx_par = state_reg.tx_par ^ state_reg.tx_shift[0];
                                    state_next.tx_shift = {1'b0, state_reg.tx_shift[7:1]};
                                end
                                else
                                begin
                                    state_next.tx_par = state_reg.tx_par ^ odd_v;
                                    state_next.txd = state_reg.tx_par ^ odd_v;
                                end
                                if (bit_inc == state_reg.frame)
                                begin
                                    state_next.tx_phase = acia_pkg::PH_STOP;
                                    state_next.tx_bit = '0;
                                end
                            end
                        end
                        else if (state_reg.tx_phase == acia_pkg::PH_STOP)
                        begin
                            if (tick_inc == state_reg.divide)
                            begin
                                state_next.tx_tick = '0;
                                bit_inc = state_reg.tx_bit + 4'd1;
                                state_next.tx_bit = bit_inc;
                                state_next.txd = 1'b1;
                                if (bit_inc == {2'b00, state_reg.stops})
                                begin
                                    state_next.tx_phase = acia_pkg::PH_START;
                                end
                            end
                        end
                        else
                        begin
                            state_next.tx_phase = acia_pkg::PH_START;
                            state_next.tx_tick = '0;
                            if ((state_reg.status & acia_pkg::ST_TDRE) == 8'h00
                                && (state_reg.status & acia_pkg::ST_CTS) == 8'h00)
                            begin
                                state_next.tx_phase = acia_pkg::PH_DATA;
                                state_next.tx_shift = state_reg.tx_data;
                                state_next.tx_bit = '0;
                                state_next.tx_par = 1'b0;
                                state_next.status = state_reg.status | acia_pkg::ST_TDRE;
                                state_next.txd = 1'b0;
                            end
                            else
                            begin
                                state_next.txd = !state_reg.brk;
                            end
                        end
                    end
                    state_next = acia_pkg::irq_update(state_next);
                end
            end
            acia_pkg::OP_RXD:
            begin
                state_next.rx_level = item.level;
            end
            acia_pkg::OP_CTS:
            begin
                state_next.status = item.level ? (state_reg.status | acia_pkg::ST_CTS)
                                               : (state_reg.status & ~acia_pkg::ST_CTS);
            end
            acia_pkg::OP_DCD:
            begin
                state_next.carrier = item.level;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acia_pkg::STATE_RESET;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    assign result.rd    = rd;
    assign result.txd   = state_next.txd;
    assign result.rts   = state_next.rts;
    assign result.irq_n = state_next.irq_n;

endmodule

`default_nettype wire

// ===== src/acia_checker.sv =====
// Port-level checks for the asynchronous serial interface and their binding.
`timescale 1ns / 1ps
`default_nettype none

module acia_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [acia_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // drop input ready only while a result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // a stall on both sides keeps input blocked until the output is ready
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && !m_tready |=> m_tready || !s_tready)
        else $error("input reopened while output still stalled");

    // keep the padding of result data at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[acia_pkg::OUT_TDATA_W-1:11] == '0)
        else $error("result padding not zero");

endmodule

bind acia_serial_interface acia_checker u_acia_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
